FILE: rtl/tbi_pkg.sv
package tbi_pkg;

  localparam int ValueBits = 16;
  localparam int MaxXPoints = 16;
  localparam int MaxYPoints = 16;
  localparam int IdxBits = 4;
  localparam int CntBits = 5;
  localparam int DiffBits = ValueBits + 1;
  localparam int ProdBits = 2 * ValueBits + 2;
  localparam int QuotBits = ProdBits + 1;
  localparam int SumBits = QuotBits + 1;

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_WRITE_X = 2'd1,
    OP_WRITE_Y = 2'd2,
    OP_WRITE_Z = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_FETCH,
    ST_DIV1,
    ST_DIV2,
    ST_DIV3,
    ST_DONE
  } state_t;

  typedef enum logic {
    REG_X_USED = 1'b0,
    REG_Y_USED = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]                  operation;
    logic [IdxBits-1:0]          index_x;
    logic [IdxBits-1:0]          index_y;
    logic signed [ValueBits-1:0] write_value;
    logic signed [ValueBits-1:0] query_x;
    logic signed [ValueBits-1:0] query_y;
  } item_t;

  typedef struct packed {
    logic signed [ValueBits-1:0] interp_value;
    logic                        x_clamped;
    logic                        y_clamped;
  } result_t;

  function automatic logic signed [ValueBits-1:0] sat(input logic signed [SumBits-1:0] v);
    logic signed [SumBits-1:0] vmax;
    logic signed [SumBits-1:0] vmin;
    vmax = SumBits'((64'sd1 <<< (ValueBits - 1)) - 64'sd1);
    vmin = -vmax - SumBits'(1);
    if (v > vmax) return ValueBits'(vmax);
    if (v < vmin) return ValueBits'(vmin);
    return ValueBits'(v);
  endfunction

  function automatic logic [CntBits-1:0] used(input logic [CntBits-1:0] r,
                                              input logic [CntBits-1:0] maxv);
    if (r == '0) return CntBits'(1);
    if (r > maxv) return maxv;
    return r;
  endfunction

endpackage

FILE: rtl/tbi_muldiv.sv
module tbi_muldiv import tbi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic signed [DiffBits-1:0] a,
  input  logic signed [DiffBits-1:0] b,
  input  logic signed [DiffBits-1:0] c,
  output logic                       done,
  output logic signed [QuotBits-1:0] q
);

  localparam int StepBits = $clog2(ProdBits + 1);

  logic                  running;
  logic [StepBits-1:0]   step;
  logic [ProdBits-1:0]   acc;
  logic [DiffBits-1:0]   rem;
  logic [DiffBits-1:0]   uc;
  logic                  neg;
  logic [DiffBits-1:0]   ua, ub, ucn;
  logic [DiffBits:0]     rem_sh;
  logic                  qbit;
  logic [DiffBits:0]     rem_sub;

  assign ua  = a[DiffBits-1] ? DiffBits'(-a) : DiffBits'(a);
  assign ub  = b[DiffBits-1] ? DiffBits'(-b) : DiffBits'(b);
  assign ucn = c[DiffBits-1] ? DiffBits'(-c) : DiffBits'(c);

  assign rem_sh  = {rem, acc[ProdBits-1]};
  assign qbit    = rem_sh >= {1'b0, uc};
  assign rem_sub = rem_sh - {1'b0, uc};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + StepBits'(1);
        if (step == StepBits'(ProdBits - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= ProdBits'(ua * ub);
      rem <= '0;
      uc  <= ucn;
      neg <= a[DiffBits-1] ^ b[DiffBits-1] ^ c[DiffBits-1];
    end else if (running) begin
      rem <= qbit ? rem_sub[DiffBits-1:0] : rem_sh[DiffBits-1:0];
      acc <= {acc[ProdBits-2:0], qbit};
    end
  end

  assign q = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});

endmodule

FILE: rtl/table_bilinear_interp_2d.sv
// Bilinear table interpolator. Load beats (operation 1..3) write a breakpoint or grid
// cell in the cycle they are accepted and leave busy low. A query beat keeps busy high
// while it scans both breakpoint tables through their read ports, picks the brackets,
// fetches the bracketing breakpoints and four grid cells one per cycle, runs three
// multiply-divides on one shared bit-serial divider (an axis whose neighbours are equal
// skips its divide), and finally holds done high for 1 cycle to show the result.
// The receiver cannot stall, so capture it then.
// Configuration is taken any time but must only change while busy is low.
module table_bilinear_interp_2d import tbi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  item_t       item,
  output logic        busy,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CntBits-1:0] x_used, y_used;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_used <= CntBits'(MaxXPoints);
      y_used <= CntBits'(MaxYPoints);
    end else if (cfg_wr) begin
      if (reg_idx_t'(paddr[2]) == REG_X_USED) x_used <= pwdata[CntBits-1:0];
      else                                    y_used <= pwdata[CntBits-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx_t'(paddr[2]) == REG_X_USED) prdata[CntBits-1:0] = x_used;
    else                                    prdata[CntBits-1:0] = y_used;
  end

  logic signed [ValueBits-1:0] xmem [MaxXPoints];
  logic signed [ValueBits-1:0] ymem [MaxYPoints];
  logic signed [ValueBits-1:0] zmem [MaxXPoints*MaxYPoints];

  state_t state, state_next;
  logic   accept;

  logic signed [ValueBits-1:0] qx, qy;
  logic [CntBits-1:0]   nx, ny, cnt;
  logic                 pv;
  logic [IdxBits-1:0]   pidx;
  logic [CntBits-1:0]   bx, ax, by, ay;
  logic [IdxBits-1:0]   xl, xh, yl, yh;
  logic                 cx, cy;
  logic [2:0]           fstep;
  logic                 issued;

  logic [IdxBits-1:0]        xaddr, yaddr;
  logic [2*IdxBits-1:0]      zaddr;
  logic signed [ValueBits-1:0] xrd, yrd, zrd;
  logic signed [ValueBits-1:0] xlo, xhi, ylo, yhi, z11, z12, z21, z22, r1, r2, zout;

  logic                       div_go, div_done;
  logic signed [DiffBits-1:0] da, db, dc;
  logic signed [ValueBits-1:0] dbase;
  logic signed [QuotBits-1:0] dq;
  logic signed [ValueBits-1:0] dres;

  assign accept = start && !busy;
  assign busy   = state != ST_IDLE;
  assign done   = state == ST_DONE;
  assign result = '{interp_value: zout, x_clamped: cx, y_clamped: cy};

  always_ff @(posedge clk) begin
    if (accept && op_t'(item.operation) == OP_WRITE_X) xmem[item.index_x] <= item.write_value;
    if (accept && op_t'(item.operation) == OP_WRITE_Y) ymem[item.index_y] <= item.write_value;
    if (accept && op_t'(item.operation) == OP_WRITE_Z)
      zmem[{item.index_y, item.index_x}] <= item.write_value;
    xrd <= xmem[xaddr];
    yrd <= ymem[yaddr];
    zrd <= zmem[zaddr];
  end

  always_comb begin
    xaddr = cnt[IdxBits-1:0];
    yaddr = cnt[IdxBits-1:0];
    zaddr = {yl, xl};
    if (state == ST_FETCH) begin
      case (fstep)
        3'd0:    begin xaddr = xl; yaddr = yl; zaddr = {yl, xl}; end
        3'd1:    begin xaddr = xh; yaddr = yh; zaddr = {yl, xh}; end
        3'd2:    zaddr = {yh, xl};
        default: zaddr = {yh, xh};
      endcase
    end
  end

  always_comb begin
    da    = DiffBits'(qx) - DiffBits'(xhi);
    db    = DiffBits'(z11) - DiffBits'(z12);
    dc    = DiffBits'(xlo) - DiffBits'(xhi);
    dbase = z12;
    case (state)
      ST_DIV2: begin
        db    = DiffBits'(z21) - DiffBits'(z22);
        dbase = z22;
      end
      ST_DIV3: begin
        da    = DiffBits'(qy) - DiffBits'(ylo);
        db    = DiffBits'(r2) - DiffBits'(r1);
        dc    = DiffBits'(yhi) - DiffBits'(ylo);
        dbase = r1;
      end
      default: ;
    endcase
  end

  assign div_go = (state == ST_DIV1 || state == ST_DIV2 || state == ST_DIV3)
                  && !issued && dc != '0;
  assign dres   = sat(SumBits'(dbase) + SumBits'(dq));

  tbi_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .a    (da),
    .b    (db),
    .c    (dc),
    .done (div_done),
    .q    (dq)
  );

  logic step_end;
  assign step_end = issued ? div_done : (dc == '0);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && op_t'(item.operation) == OP_QUERY) state_next = ST_SCAN;
      ST_SCAN:  if (cnt == CntBits'(MaxXPoints) && !pv) state_next = ST_PICK;
      ST_PICK:  state_next = ST_FETCH;
      ST_FETCH: if (fstep == 3'd4) state_next = ST_DIV1;
      ST_DIV1:  if (step_end) state_next = ST_DIV2;
      ST_DIV2:  if (step_end) state_next = ST_DIV3;
      ST_DIV3:  if (step_end) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= 1'b0;
      pv     <= 1'b0;
    end else begin
      if (div_go) issued <= 1'b1;
      else if (div_done) issued <= 1'b0;
      pv <= state == ST_SCAN && cnt < CntBits'(MaxXPoints);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        qx  <= item.query_x;
        qy  <= item.query_y;
        nx  <= used(x_used, CntBits'(MaxXPoints));
        ny  <= used(y_used, CntBits'(MaxYPoints));
        cnt <= '0;
        bx <= '0; ax <= '0; by <= '0; ay <= '0;
      end
      ST_SCAN: begin
        if (cnt < CntBits'(MaxXPoints)) cnt <= cnt + CntBits'(1);
        pidx <= cnt[IdxBits-1:0];
        if (pv && {1'b0, pidx} < nx) begin
          bx <= bx + CntBits'(xrd < qx);
          ax <= ax + CntBits'(xrd <= qx);
        end
        if (pv && {1'b0, pidx} < ny) begin
          by <= by + CntBits'(yrd < qy);
          ay <= ay + CntBits'(yrd <= qy);
        end
      end
      ST_PICK: begin
        fstep <= '0;
        if (bx == '0) begin
          xl <= '0; xh <= '0; cx <= 1'b1;
        end else if (ax == nx) begin
          xl <= IdxBits'(nx - CntBits'(1)); xh <= IdxBits'(nx - CntBits'(1)); cx <= 1'b1;
        end else begin
          xl <= IdxBits'(bx - CntBits'(1)); xh <= IdxBits'(bx); cx <= 1'b0;
        end
        if (by == '0) begin
          yl <= '0; yh <= '0; cy <= 1'b1;
        end else if (ay == ny) begin
          yl <= IdxBits'(ny - CntBits'(1)); yh <= IdxBits'(ny - CntBits'(1)); cy <= 1'b1;
        end else begin
          yl <= IdxBits'(by - CntBits'(1)); yh <= IdxBits'(by); cy <= 1'b0;
        end
      end
      ST_FETCH: begin
        fstep <= fstep + 3'd1;
        case (fstep)
          3'd1:    begin xlo <= xrd; ylo <= yrd; z11 <= zrd; end
          3'd2:    begin xhi <= xrd; yhi <= yrd; z12 <= zrd; end
          3'd3:    z21 <= zrd;
          3'd4:    z22 <= zrd;
          default: ;
        endcase
      end
      ST_DIV1: if (step_end) r1 <= issued ? dres : dbase;
      ST_DIV2: if (step_end) r2 <= issued ? dres : dbase;
      ST_DIV3: if (step_end) zout <= issued ? dres : dbase;
      default: ;
    endcase
  end

endmodule

FILE: rtl/tbi_checker.sv
module tbi_checker import tbi_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input item_t   item,
  input logic    busy,
  input logic    done
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held over two cycles");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op_t'(item.operation) == OP_QUERY) |=> busy)
    else $error("query beat did not raise busy");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op_t'(item.operation) != OP_QUERY) |=> !busy)
    else $error("load beat raised busy");

  a_reset: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("not idle after reset");

endmodule

bind table_bilinear_interp_2d tbi_checker u_tbi_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .item  (item),
  .busy  (busy),
  .done  (done)
);

FILE: test/table_bilinear_interp_2d_test.sv
module table_bilinear_interp_2d_test;
  import tbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  item_t       item = '0;
  logic        busy;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  table_bilinear_interp_2d dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic signed [ValueBits-1:0] xbp [MaxXPoints];
  logic signed [ValueBits-1:0] ybp [MaxYPoints];
  logic signed [ValueBits-1:0] zcell [MaxYPoints][MaxXPoints];
  logic [CntBits-1:0] x_used_reg = 5'd16;
  logic [CntBits-1:0] y_used_reg = 5'd16;

  // stimulus-side view of the tables
  int gen_x [MaxXPoints];
  int gen_y [MaxYPoints];
  int gen_nx = 16;
  int gen_ny = 16;

  item_t   pending [$];
  result_t interp_due [$];
  int      fails = 0;
  int      gap = 0;
  bit      no_gaps = 0;
  int      idle_cycles = 0;

  function automatic int points_in_use(logic [CntBits-1:0] r, int maxv);
    if (r == 0) return 1;
    if (r > maxv) return maxv;
    return int'(r);
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic bit find_span(input bit on_y, input int n, input longint q,
                                   output int lo, output int hi);
    int below, atmost;
    longint e;
    below = 0;
    atmost = 0;
    for (int i = 0; i < n; i++) begin
      e = on_y ? longint'(ybp[i]) : longint'(xbp[i]);
      if (e < q) below++;
      if (e <= q) atmost++;
    end
    if (below == 0) begin
      lo = 0; hi = 0; return 1'b1;
    end
    if (atmost == n) begin
      lo = n - 1; hi = n - 1; return 1'b1;
    end
    lo = below - 1;
    hi = below;
    return 1'b0;
  endfunction

  function automatic longint row_blend(longint qx, longint xlo, longint xhi,
                                       longint zlo, longint zhi);
    longint den;
    den = xlo - xhi;
    if (den == 0) return zhi;
    return clip16(zhi + ((qx - xhi) * (zlo - zhi)) / den);
  endfunction

  function automatic result_t interpolate(item_t it);
    result_t r;
    int nx, ny, xl, xh, yl, yh;
    longint qx, qy, r1, r2, den, z;
    qx = longint'(it.query_x);
    qy = longint'(it.query_y);
    nx = points_in_use(x_used_reg, MaxXPoints);
    ny = points_in_use(y_used_reg, MaxYPoints);
    r.x_clamped = find_span(1'b0, nx, qx, xl, xh);
    r.y_clamped = find_span(1'b1, ny, qy, yl, yh);
    r1 = row_blend(qx, xbp[xl], xbp[xh], zcell[yl][xl], zcell[yl][xh]);
    r2 = row_blend(qx, xbp[xl], xbp[xh], zcell[yh][xl], zcell[yh][xh]);
    den = longint'(ybp[yh]) - longint'(ybp[yl]);
    z = r1;
    if (den != 0) z = clip16(r1 + ((qy - ybp[yl]) * (r2 - r1)) / den);
    r.interp_value = ValueBits'(z);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        case (op_t'(item.operation))
          OP_WRITE_X: xbp[item.index_x] = item.write_value;
          OP_WRITE_Y: ybp[item.index_y] = item.write_value;
          OP_WRITE_Z: zcell[item.index_y][item.index_x] = item.write_value;
          default: interp_due.push_back(interpolate(item));
        endcase
      end
      if (!(start && busy)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          start <= 1'b0;
        end else if (pending.size() > 0) begin
          item <= pending.pop_front();
          start <= 1'b1;
          if (no_gaps) gap <= 0;
          else if ($urandom_range(0, 99) < 60) gap <= 0;
          else if ($urandom_range(0, 99) < 85) gap <= $urandom_range(1, 3);
          else gap <= $urandom_range(10, 40);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (interp_due.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, result);
        fails++;
      end else begin
        result_t want;
        want = interp_due.pop_front();
        if (result.interp_value !== want.interp_value)
          $display("%0t: interp_value expected %0d actual %0d", $realtime,
                   want.interp_value, result.interp_value);
        if (result.x_clamped !== want.x_clamped)
          $display("%0t: x_clamped expected %0b actual %0b", $realtime,
                   want.x_clamped, result.x_clamped);
        if (result.y_clamped !== want.y_clamped)
          $display("%0t: y_clamped expected %0b actual %0b", $realtime,
                   want.y_clamped, result.y_clamped);
        if (result !== want) fails++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic item_t beat(op_t op, int ix, int iy, int wv, int qx, int qy);
    item_t it;
    it.operation = op;
    it.index_x = ix[3:0];
    it.index_y = iy[3:0];
    it.write_value = wv[15:0];
    it.query_x = qx[15:0];
    it.query_y = qy[15:0];
    return it;
  endfunction

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic push_write(op_t op, int ix, int iy, int wv);
    pending.push_back(beat(op, ix, iy, wv, rnd16(), rnd16()));
    if (op == OP_WRITE_X) gen_x[ix] = wv;
    if (op == OP_WRITE_Y) gen_y[iy] = wv;
  endtask

  task automatic push_query(int qx, int qy);
    pending.push_back(beat(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 15),
                           rnd16(), qx, qy));
  endtask

  task automatic load_axis(op_t op);
    int v, mode;
    mode = $urandom_range(0, 9);
    v = int'($urandom_range(0, 20000)) - 30000;
    for (int i = 0; i < 16; i++) begin
      if (mode == 0) v = rnd16();
      else if ($urandom_range(0, 9) == 0) v = v;
      else v = v + $urandom_range(1, mode < 5 ? 600 : 4000);
      if (v > 32767) v = 32767;
      push_write(op, op == OP_WRITE_X ? i : $urandom_range(0, 15),
                 op == OP_WRITE_Y ? i : $urandom_range(0, 15), v);
    end
  endtask

  function automatic int pick_coord(bit on_y);
    int n, lo, hi, k, t;
    n = on_y ? gen_ny : gen_nx;
    k = $urandom_range(0, n - 1);
    lo = on_y ? gen_y[0] : gen_x[0];
    hi = on_y ? gen_y[n - 1] : gen_x[n - 1];
    if (lo > hi) begin
      t = lo; lo = hi; hi = t;
    end
    case ($urandom_range(0, 9))
      0: return rnd16();
      1: return on_y ? gen_y[k] : gen_x[k];
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      default: begin
        lo = lo - 300 < -32768 ? -32768 : lo - 300;
        hi = hi + 300 > 32767 ? 32767 : hi + 300;
        return lo + int'($urandom_range(0, hi - lo));
      end
    endcase
  endfunction

  task automatic wait_idle();
    while (pending.size() > 0 || start || interp_due.size() > 0 || busy)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_t r, int v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (r == REG_X_USED) begin
      x_used_reg = v[4:0];
      gen_nx = points_in_use(v[4:0], MaxXPoints);
    end else begin
      y_used_reg = v[4:0];
      gen_ny = points_in_use(v[4:0], MaxYPoints);
    end
  endtask

  int xs [9] = '{16, 1, 0, 31, 5, 16, 2, 17, 9};
  int ys [9] = '{16, 1, 31, 0, 3, 1, 16, 2, 12};

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // every entry written before the first query
    for (int i = 0; i < 16; i++) push_write(OP_WRITE_X, i, 15 - i, -30000 + 4000 * i);
    for (int i = 0; i < 16; i++) push_write(OP_WRITE_Y, 15 - i, i, -30000 + 4000 * i);
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        push_write(OP_WRITE_Z, c, r, (r + c) % 5 == 0 ? ((r & 1) ? 32767 : -32768) : rnd16());
    push_query(-32768, -32768);
    push_query(32767, 32767);
    push_query(-32768, 32767);
    push_query(-30000, -30000);
    push_query(30000, 30000);
    push_query(-28000, -26001);
    push_query(1, -1);
    push_write(OP_WRITE_X, 4, 0, -14000);
    push_write(OP_WRITE_Y, 0, 4, -14000);
    push_query(-14000, -14000);
    push_query(-13999, -14001);
    push_write(OP_WRITE_X, 4, 0, -14000);
    wait_idle();
    no_gaps = 1;
    for (int p = 0; p < 9; p++) begin
      set_reg(REG_X_USED, xs[p]);
      set_reg(REG_Y_USED, ys[p]);
      no_gaps = (p % 3 == 1);
      for (int s = 0; s < 2; s++) begin
        if ($urandom_range(0, 2) == 0) load_axis(OP_WRITE_X);
        if ($urandom_range(0, 2) == 0) load_axis(OP_WRITE_Y);
        repeat ($urandom_range(5, 15))
          push_write(OP_WRITE_Z, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 32767 : -32768)
                                               : rnd16());
        repeat ($urandom_range(12, 20)) push_query(pick_coord(1'b0), pick_coord(1'b1));
      end
      wait_idle();
    end
    repeat (200) @(posedge clk);
    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
